[rtl/core/sequence_drop_tracker_unit_assert.svh]
// Assertion macros shared by the checker of the sequence drop tracker.
// Standalone header: no dependencies beyond the including module's signals.
`ifndef SEQUENCE_DROP_TRACKER_UNIT_ASSERT_SVH
`define SEQUENCE_DROP_TRACKER_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SDT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SDT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/sdt_pkg.sv]
// Shared types and constants of the sequence drop tracker.
// No dependencies; imported by every module of the block.
package sdt_pkg;

    localparam int MOD_W  = 17;
    localparam int TIME_W = 63;
    localparam int CFG_W  = 63;

    localparam logic KIND_FRAME  = 1'b0;
    localparam logic KIND_LOOKUP = 1'b1;

    localparam logic CFG_MODULUS = 1'b0;
    localparam logic CFG_IDLE_NS = 1'b1;

    localparam logic [MOD_W-1:0]  MODULUS_RESET = 17'd4000;
    localparam logic [TIME_W-1:0] IDLE_NS_RESET = 63'd1000000000;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_TABLE_FULL   = 2'd1,
        ST_NOT_FOUND    = 2'd2,
        ST_OUT_OF_RANGE = 2'd3
    } t_status;

    typedef struct packed {
        logic              kind;
        logic [15:0]       app_id;
        logic [63:0]       sv_key;
        logic [15:0]       smp_cnt;
        logic              has_timestamp;
        logic [TIME_W-1:0] rx_time_ns;
    } t_in_item;

    typedef struct packed {
        t_status     status;
        logic [14:0] gap;
        logic [3:0]  stream_index;
        logic [31:0] frames_received;
        logic [31:0] frames_dropped;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_SEARCH,
        S_LOAD,
        S_EVAL,
        S_AGE,
        S_MOD,
        S_ADV,
        S_GAP,
        S_WRITE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic    capture;
        logic    srch_init;
        logic    srch_rd;
        logic    take_found;
        logic    alloc;
        logic    load;
        logic    seed;
        logic    tdiff;
        logic    age;
        logic    mod_start;
        logic    mod_step;
        logic    adv;
        logic    gap;
        logic    wr;
        logic    set_status;
        t_status status;
        logic    out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic is_lookup;
        logic cnt_oor;
        logic match;
        logic more;
        logic full;
        logic seeded;
        logic reseed;
        logic restart;
        logic stale;
        logic mod_done;
        logic out_free;
    } t_dp_stat;

endpackage

[rtl/core/sequence_drop_tracker_unit.sv]
// Sequence drop tracker: per-stream frame and drop counters keyed on app id
// and stream key. Top level joining sdt_ctrl and sdt_datapath; uses sdt_pkg.
//
// Usage:
//   Request channel i_in (valid/stall): a frame (kind 0) or a lookup (kind 1).
//   Result channel o_out (valid/stall): exactly one result per request.
//   Configuration: i_cfg_we writes i_cfg_data to register i_cfg_index
//   (0 sample counter modulus, 1 idle reseed time in ns); write only while idle.
// Throughput and search:
//   One request is in flight at a time; o_in_stall is high while it is worked.
//   The table is searched one entry per cycle through its read port, so a
//   request whose stream sits at entry k is found after entries 0 to k are
//   read, and a miss reads all N entries in use.
//   A stored count left above a lowered modulus adds a bit-serial remainder
//   step before the advance.
// Reset clears the entry count, so the table reads as empty; no clearing pass.
// A stalled result is held in the output register; the next request is taken
// while it waits, and its own result waits until the register frees up.
module sequence_drop_tracker_unit #(
    parameter int MAX_STREAMS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_index,
    input  logic [sdt_pkg::CFG_W-1:0] i_cfg_data,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  sdt_pkg::t_in_item         i_in,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output sdt_pkg::t_out_item        o_out
);
    import sdt_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    sdt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    sdt_datapath #(
        .MAX_STREAMS (MAX_STREAMS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (i_in),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

endmodule

[rtl/core/sdt_ctrl.sv]
// Controller of the sequence drop tracker: sequences search, update and result.
// Depends on sdt_pkg for the state, command and status types.
module sdt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  sdt_pkg::t_dp_stat i_stat,
    output sdt_pkg::t_dp_cmd  o_cmd,
    output logic              o_in_stall
);
    import sdt_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_CHECK;
            end
            S_CHECK: begin
                if (!i_stat.is_lookup && i_stat.cnt_oor) n_state = S_DONE;
                else n_state = S_SEARCH;
            end
            S_SEARCH: begin
                priority if (i_stat.match) n_state = S_LOAD;
                else if (i_stat.more) n_state = S_SEARCH;
                else if (i_stat.is_lookup) n_state = S_DONE;
                else if (i_stat.full) n_state = S_DONE;
                else n_state = S_EVAL;
            end
            S_LOAD: n_state = S_EVAL;
            S_EVAL: begin
                priority if (i_stat.is_lookup) n_state = S_DONE;
                else if (!i_stat.seeded) n_state = S_WRITE;
                else n_state = S_AGE;
            end
            S_AGE: begin
                priority if (i_stat.reseed || i_stat.restart) n_state = S_WRITE;
                else if (i_stat.stale) n_state = S_MOD;
                else n_state = S_ADV;
            end
            S_MOD: begin
                if (i_stat.mod_done) n_state = S_ADV;
            end
            S_ADV:   n_state = S_GAP;
            S_GAP:   n_state = S_WRITE;
            S_WRITE: n_state = S_DONE;
            S_DONE: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_cmd.status = ST_OK;
        unique case (r_state)
            S_IDLE: o_cmd.capture = i_in_valid;
            S_CHECK: begin
                if (!i_stat.is_lookup && i_stat.cnt_oor) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = ST_OUT_OF_RANGE;
                end else begin
                    o_cmd.srch_init = 1'b1;
                end
            end
            S_SEARCH: begin
                priority if (i_stat.match) begin
                    o_cmd.take_found = 1'b1;
                end else if (i_stat.more) begin
                    o_cmd.srch_rd = 1'b1;
                end else if (i_stat.is_lookup) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = ST_NOT_FOUND;
                end else if (i_stat.full) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = ST_TABLE_FULL;
                end else begin
                    o_cmd.alloc = 1'b1;
                end
            end
            S_LOAD: o_cmd.load = 1'b1;
            S_EVAL: begin
                if (!i_stat.is_lookup) begin
                    if (!i_stat.seeded) o_cmd.seed = 1'b1;
                    else o_cmd.tdiff = 1'b1;
                end
            end
            S_AGE: begin
                o_cmd.age = 1'b1;
                o_cmd.mod_start = !(i_stat.reseed || i_stat.restart) && i_stat.stale;
            end
            S_MOD:   o_cmd.mod_step = !i_stat.mod_done;
            S_ADV:   o_cmd.adv = 1'b1;
            S_GAP:   o_cmd.gap = 1'b1;
            S_WRITE: o_cmd.wr = 1'b1;
            S_DONE:  o_cmd.out_load = i_stat.out_free;
            default: o_cmd.capture = 1'b0;
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

[rtl/core/sdt_datapath.sv]
// Datapath of the sequence drop tracker: stream table, sequence arithmetic,
// remainder unit, configuration and output register. Depends on sdt_pkg.
module sdt_datapath #(
    parameter int MAX_STREAMS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_index,
    input  logic [sdt_pkg::CFG_W-1:0] i_cfg_data,
    input  sdt_pkg::t_in_item         i_in,
    input  sdt_pkg::t_dp_cmd          i_cmd,
    output sdt_pkg::t_dp_stat         o_stat,
    input  logic                      i_out_stall,
    output logic                      o_out_valid,
    output sdt_pkg::t_out_item        o_out
);
    import sdt_pkg::*;

    localparam int IDX_W = (MAX_STREAMS > 1) ? $clog2(MAX_STREAMS) : 1;
    localparam int CNT_W = $clog2(MAX_STREAMS + 1);

    typedef struct packed {
        logic [15:0]       app_id;
        logic [63:0]       key;
        logic              seeded;
        logic              time_valid;
        logic [15:0]       last_count;
        logic [TIME_W-1:0] last_time;
        logic [31:0]       received;
        logic [31:0]       dropped;
    } t_entry;

    // configuration
    logic [MOD_W-1:0]  r_modulus;
    logic [TIME_W-1:0] r_idle_ns;

    // control state
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_rd_idx;
    logic             r_cmp_valid;
    logic [4:0]       r_mod_cnt;
    logic             r_out_valid;

    // payload
    t_in_item          r_item;
    logic [IDX_W-1:0]  r_cmp_idx;
    logic [IDX_W-1:0]  r_entry_idx;
    t_entry            mem [MAX_STREAMS];
    t_entry            r_rd_data;
    t_entry            r_w;
    t_status           r_status;
    logic [14:0]       r_gap;
    logic              r_later;
    logic [TIME_W-1:0] r_tdiff;
    logic [MOD_W-1:0]  r_rem;
    logic [15:0]       r_shift;
    logic [MOD_W-1:0]  r_adv;
    t_out_item         r_out;

    logic [MOD_W-1:0] m_eff;
    logic [MOD_W-1:0] cnt_ext;
    logic [MOD_W-1:0] last_ext;
    logic [IDX_W-1:0] rd_addr;
    logic [TIME_W:0]  tsub;
    logic [MOD_W:0]   rem_sh;
    logic [MOD_W:0]   adv_sum;
    logic [MOD_W:0]   adv_red;
    logic             adv_ok;

    // a modulus below two behaves as two
    assign m_eff    = (r_modulus < MOD_W'(2)) ? MOD_W'(2) : r_modulus;
    assign cnt_ext  = {1'b0, r_item.smp_cnt};
    assign last_ext = {1'b0, r_w.last_count};
    assign rd_addr  = i_cmd.take_found ? r_cmp_idx : r_rd_idx[IDX_W-1:0];
    assign tsub     = {1'b0, r_item.rx_time_ns} - {1'b0, r_w.last_time};
    assign rem_sh   = {r_rem, r_shift[15]};
    assign adv_sum  = {1'b0, cnt_ext} + {1'b0, m_eff} - {1'b0, r_rem};
    assign adv_red  = (adv_sum >= {1'b0, m_eff}) ? (adv_sum - {1'b0, m_eff}) : adv_sum;
    assign adv_ok   = (r_adv != '0) && (r_adv <= (m_eff >> 1));

    always_comb begin
        o_stat.is_lookup = (r_item.kind == KIND_LOOKUP);
        o_stat.cnt_oor   = (cnt_ext >= m_eff);
        o_stat.match     = r_cmp_valid && (r_rd_data.app_id == r_item.app_id)
                           && (r_rd_data.key == r_item.sv_key);
        o_stat.more      = (r_rd_idx < r_count);
        o_stat.full      = (r_count >= CNT_W'(MAX_STREAMS));
        o_stat.seeded    = r_w.seeded;
        o_stat.reseed    = r_item.has_timestamp && r_w.time_valid && r_later
                           && (r_tdiff > r_idle_ns);
        o_stat.restart   = (r_item.smp_cnt == '0) && (last_ext != (m_eff - MOD_W'(1)));
        o_stat.stale     = (last_ext >= m_eff);
        o_stat.mod_done  = (r_mod_cnt == '0);
        o_stat.out_free  = !r_out_valid || !i_out_stall;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus   <= MODULUS_RESET;
            r_idle_ns   <= IDLE_NS_RESET;
            r_count     <= '0;
            r_rd_idx    <= '0;
            r_cmp_valid <= 1'b0;
            r_mod_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_MODULUS: r_modulus <= i_cfg_data[MOD_W-1:0];
                    CFG_IDLE_NS: r_idle_ns <= i_cfg_data[TIME_W-1:0];
                    default:     r_modulus <= r_modulus;
                endcase
            end
            r_cmp_valid <= i_cmd.srch_rd;
            if (i_cmd.srch_init) r_rd_idx <= '0;
            else if (i_cmd.srch_rd) r_rd_idx <= r_rd_idx + CNT_W'(1);
            if (i_cmd.alloc) r_count <= r_count + CNT_W'(1);
            if (i_cmd.mod_start) r_mod_cnt <= 5'd16;
            else if (i_cmd.mod_step) r_mod_cnt <= r_mod_cnt - 5'd1;
            if (i_cmd.out_load) r_out_valid <= 1'b1;
            else if (!i_out_stall) r_out_valid <= 1'b0;
        end
    end

    // stream table: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) mem[r_entry_idx] <= r_w;
        r_rd_data <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item   <= i_in;
            r_status <= ST_OK;
            r_gap    <= '0;
        end
        if (i_cmd.set_status) r_status <= i_cmd.status;
        if (i_cmd.srch_rd) r_cmp_idx <= r_rd_idx[IDX_W-1:0];
        if (i_cmd.take_found) r_entry_idx <= r_cmp_idx;

        if (i_cmd.alloc) begin
            r_entry_idx <= r_count[IDX_W-1:0];
            r_w         <= '0;
            r_w.app_id  <= r_item.app_id;
            r_w.key     <= r_item.sv_key;
        end
        if (i_cmd.load) r_w <= r_rd_data;

        if (i_cmd.seed) begin
            r_w.received   <= r_w.received + 32'd1;
            r_w.last_count <= r_item.smp_cnt;
            r_w.seeded     <= 1'b1;
            if (r_item.has_timestamp) begin
                r_w.last_time  <= r_item.rx_time_ns;
                r_w.time_valid <= 1'b1;
            end
        end

        if (i_cmd.tdiff) begin
            r_w.received <= r_w.received + 32'd1;
            r_later      <= !tsub[TIME_W] && (tsub[TIME_W-1:0] != '0);
            r_tdiff      <= tsub[TIME_W-1:0];
        end

        if (i_cmd.age) begin
            r_rem <= last_ext;
            if (o_stat.reseed) begin
                r_w.last_count <= r_item.smp_cnt;
                r_w.last_time  <= r_item.rx_time_ns;
            end else begin
                if (r_item.has_timestamp) begin
                    r_w.last_time  <= r_item.rx_time_ns;
                    r_w.time_valid <= 1'b1;
                end
                if (o_stat.restart) r_w.last_count <= '0;
            end
        end

        // restoring remainder of a stale stored count, one bit a cycle
        if (i_cmd.mod_start) begin
            r_rem   <= '0;
            r_shift <= r_w.last_count;
        end else if (i_cmd.mod_step) begin
            r_rem   <= (rem_sh >= {1'b0, m_eff}) ? MOD_W'(rem_sh - {1'b0, m_eff})
                                                 : rem_sh[MOD_W-1:0];
            r_shift <= {r_shift[14:0], 1'b0};
        end

        if (i_cmd.adv) r_adv <= adv_red[MOD_W-1:0];

        if (i_cmd.gap && adv_ok) begin
            r_w.last_count <= r_item.smp_cnt;
            r_w.dropped    <= r_w.dropped + 32'(r_adv) - 32'd1;
            r_gap          <= 15'(r_adv - MOD_W'(1));
        end

        if (i_cmd.out_load) begin
            r_out.status <= r_status;
            if (r_status == ST_OK) begin
                r_out.gap             <= r_gap;
                r_out.stream_index    <= 4'(r_entry_idx);
                r_out.frames_received <= r_w.received;
                r_out.frames_dropped  <= r_w.dropped;
            end else begin
                r_out.gap             <= '0;
                r_out.stream_index    <= '0;
                r_out.frames_received <= '0;
                r_out.frames_dropped  <= '0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

[rtl/core/sdt_checker.sv]
// Port-level checker of the sequence drop tracker, bound to the top level.
// Depends on sdt_pkg and the macros in sequence_drop_tracker_unit_assert.svh.
`include "sequence_drop_tracker_unit_assert.svh"

module sdt_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_cfg_we,
    input logic                      i_cfg_index,
    input logic [sdt_pkg::CFG_W-1:0] i_cfg_data,
    input logic                      i_in_valid,
    input logic                      o_in_stall,
    input sdt_pkg::t_in_item         i_in,
    input logic                      o_out_valid,
    input logic                      i_out_stall,
    input sdt_pkg::t_out_item        o_out
);
    import sdt_pkg::*;

    // a stalled result holds
    `SDT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out), "result changed while stalled")

    // one request at a time: an accepted request closes the input
    `SDT_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall, "request accepted while busy")

    // error results carry no counters
    `SDT_ASSERT_NOW(a_err_clear, i_clk, i_rst_n, o_out_valid && (o_out.status != ST_OK), (o_out.gap == '0) && (o_out.stream_index == '0) && (o_out.frames_received == '0) && (o_out.frames_dropped == '0), "error result with nonzero fields")

endmodule

bind sequence_drop_tracker_unit sdt_checker u_sdt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_cfg_we    (i_cfg_we),
    .i_cfg_index (i_cfg_index),
    .i_cfg_data  (i_cfg_data),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in        (i_in),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out)
);

[verif/sequence_drop_tracker_unit_tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for sequence_drop_tracker_unit: per-stream frame and drop
// counter checks under random handshake gaps. Depends on sdt_pkg and the RTL only.
module sequence_drop_tracker_unit_tb;
    import sdt_pkg::*;

    localparam int MAX_ENTRIES = 16;
    localparam int NUM_PHASES  = 7;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_WAIT  = 60;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int MAX_PRINTS  = 50;

    // Tracks the stream table and holds the expected report of every
    // accepted request in acceptance order.
    class drop_scoreboard;
        logic [MOD_W-1:0]  modulus;
        logic [TIME_W-1:0] idle_ns;
        int                used;
        logic [15:0]       tab_app[MAX_ENTRIES];
        logic [63:0]       tab_key[MAX_ENTRIES];
        bit                tab_seeded[MAX_ENTRIES];
        bit                tab_tvalid[MAX_ENTRIES];
        logic [15:0]       tab_last_cnt[MAX_ENTRIES];
        logic [TIME_W-1:0] tab_last_ts[MAX_ENTRIES];
        logic [31:0]       tab_rcv[MAX_ENTRIES];
        logic [31:0]       tab_drp[MAX_ENTRIES];
        t_out_item         report_q[$];
        int                errors;
        int                checked;
        int                n_frames;
        int                n_lookups;
        int                st_count[4];

        function new();
            modulus   = MODULUS_RESET;
            idle_ns   = IDLE_NS_RESET;
            used      = 0;
            errors    = 0;
            checked   = 0;
            n_frames  = 0;
            n_lookups = 0;
            for (int i = 0; i < 4; i++) st_count[i] = 0;
        endfunction

        function void set_reg(logic idx, logic [CFG_W-1:0] value);
            if (idx == CFG_MODULUS) modulus = value[MOD_W-1:0];
            else idle_ns = value[TIME_W-1:0];
        endfunction

        function int pending();
            return report_q.size();
        endfunction

        function int find_stream(logic [15:0] app, logic [63:0] key);
            for (int i = 0; i < used; i++)
                if (tab_app[i] == app && tab_key[i] == key) return i;
            return -1;
        endfunction

        function void push_status(t_status st);
            t_out_item r;
            r = '0;
            r.status = st;
            st_count[st]++;
            report_q.push_back(r);
        endfunction

        function void push_ok(int idx, int unsigned gap);
            t_out_item r;
            r.status          = ST_OK;
            r.gap             = gap[14:0];
            r.stream_index    = idx[3:0];
            r.frames_received = tab_rcv[idx];
            r.frames_dropped  = tab_drp[idx];
            st_count[ST_OK]++;
            report_q.push_back(r);
        endfunction

        function void note_request(t_in_item req);
            int idx;
            int unsigned m, last, adv, cnt;
            m   = (modulus < 2) ? 2 : 32'(modulus);
            cnt = 32'(req.smp_cnt);
            idx = find_stream(req.app_id, req.sv_key);
            if (req.kind == KIND_LOOKUP) begin
                n_lookups++;
                if (idx < 0) push_status(ST_NOT_FOUND);
                else push_ok(idx, 0);
                return;
            end
            n_frames++;
            // out-of-range counts touch no state, not even allocation
            if (cnt >= m) begin
                push_status(ST_OUT_OF_RANGE);
                return;
            end
            if (idx < 0) begin
                if (used >= MAX_ENTRIES) begin
                    push_status(ST_TABLE_FULL);
                    return;
                end
                idx = used;
                used++;
                tab_app[idx]      = req.app_id;
                tab_key[idx]      = req.sv_key;
                tab_seeded[idx]   = 1'b0;
                tab_tvalid[idx]   = 1'b0;
                tab_last_cnt[idx] = '0;
                tab_last_ts[idx]  = '0;
                tab_rcv[idx]      = '0;
                tab_drp[idx]      = '0;
            end
            tab_rcv[idx] = tab_rcv[idx] + 32'd1;
            if (!tab_seeded[idx]) begin
                tab_last_cnt[idx] = req.smp_cnt;
                tab_seeded[idx]   = 1'b1;
                if (req.has_timestamp) begin
                    tab_last_ts[idx] = req.rx_time_ns;
                    tab_tvalid[idx]  = 1'b1;
                end
                push_ok(idx, 0);
                return;
            end
            if (req.has_timestamp && tab_tvalid[idx] && req.rx_time_ns > tab_last_ts[idx] &&
                req.rx_time_ns - tab_last_ts[idx] > idle_ns) begin
                tab_last_cnt[idx] = req.smp_cnt;
                tab_last_ts[idx]  = req.rx_time_ns;
                push_ok(idx, 0);
                return;
            end
            if (req.has_timestamp) begin
                tab_last_ts[idx] = req.rx_time_ns;
                tab_tvalid[idx]  = 1'b1;
            end
            last = 32'(tab_last_cnt[idx]);
            if (cnt == 0 && last != m - 1) begin
                tab_last_cnt[idx] = '0;
                push_ok(idx, 0);
                return;
            end
            // a stored count left over from a larger modulus is folded first
            last = last % m;
            adv  = (cnt + m - last) % m;
            if (adv == 0 || adv > m / 2) begin
                push_ok(idx, 0);
                return;
            end
            tab_last_cnt[idx] = req.smp_cnt;
            tab_drp[idx]      = tab_drp[idx] + 32'(adv - 1);
            push_ok(idx, adv - 1);
        endfunction

        function void compare_field(string field, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                errors++;
                if (errors <= MAX_PRINTS)
                    $display("%0t: %s mismatch: expected %0d, actual %0d",
                             $time, field, want, got);
            end
        endfunction

        function void check_report(t_out_item got);
            t_out_item want;
            if (report_q.size() == 0) begin
                errors++;
                if (errors <= MAX_PRINTS)
                    $display("%0t: unexpected result: expected none, actual %h", $time, got);
                return;
            end
            want = report_q.pop_front();
            checked++;
            compare_field("status", 64'(want.status), 64'(got.status));
            compare_field("gap", 64'(want.gap), 64'(got.gap));
            compare_field("stream_index", 64'(want.stream_index), 64'(got.stream_index));
            compare_field("frames_received", 64'(want.frames_received),
                          64'(got.frames_received));
            compare_field("frames_dropped", 64'(want.frames_dropped),
                          64'(got.frames_dropped));
        endfunction
    endclass

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_cfg_we    = 1'b0;
    logic               i_cfg_index = 1'b0;
    logic [CFG_W-1:0]   i_cfg_data  = '0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_stall;
    t_in_item           i_in        = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    t_out_item          o_out;

    drop_scoreboard     sb = new();
    int                 cycle_count = 0;
    bit                 burst       = 1'b0;
    bit                 hold_req    = 1'b0;
    logic [MOD_W-1:0]   cur_mod     = MODULUS_RESET;
    logic [TIME_W-1:0]  cur_idle    = IDLE_NS_RESET;

    // sender-side picture of each stream, used to shape well-formed sequences
    logic [15:0]        pool_app[MAX_ENTRIES];
    logic [63:0]        pool_key[MAX_ENTRIES];
    int unsigned        pool_cnt[MAX_ENTRIES];
    logic [TIME_W-1:0]  pool_ts[MAX_ENTRIES];

    sequence_drop_tracker_unit #(
        .MAX_STREAMS(MAX_ENTRIES)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    initial begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // mostly short gaps, now and then a long one; none during a burst
    function automatic int idle_len();
        int r;
        if (burst) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_in_item frame_req(int s, int unsigned cnt, bit with_ts,
                                           logic [TIME_W-1:0] ts);
        t_in_item req;
        req.kind          = KIND_FRAME;
        req.app_id        = pool_app[s];
        req.sv_key        = pool_key[s];
        req.smp_cnt       = cnt[15:0];
        req.has_timestamp = with_ts;
        req.rx_time_ns    = ts;
        return req;
    endfunction

    function automatic t_in_item lookup_req(int s);
        t_in_item req;
        req.kind          = KIND_LOOKUP;
        req.app_id        = pool_app[s];
        req.sv_key        = pool_key[s];
        req.smp_cnt       = 16'($urandom);
        req.has_timestamp = 1'($urandom);
        req.rx_time_ns    = TIME_W'(rand64());
        return req;
    endfunction

    // next frame of a known stream: mostly in order, sometimes skipping,
    // repeating, going back, restarting or out of range
    function automatic t_in_item next_frame(int s);
        t_in_item req;
        int unsigned eff, m, adv;
        int r;
        logic [63:0] t, step_hi;
        eff = (cur_mod < 2) ? 2 : 32'(cur_mod);
        m   = (eff > 65536) ? 65536 : eff;
        adv = 1;
        r   = $urandom_range(0, 99);
        if (r >= 62 && r < 74) adv = $urandom_range(2, 6);
        else if (r >= 74 && r < 79) adv = $urandom_range(1, m / 2 + 1);
        else if (r >= 79 && r < 83) adv = 0;
        else if (r >= 83 && r < 87) adv = m - ((m > 8) ? $urandom_range(1, 4) : 1);
        req.kind   = KIND_FRAME;
        req.app_id = pool_app[s];
        req.sv_key = pool_key[s];
        if (r >= 87 && r < 91) req.smp_cnt = '0;
        else if (r >= 97 && eff < 65536) req.smp_cnt = 16'($urandom_range(eff, 65535));
        else req.smp_cnt = 16'((pool_cnt[s] + adv) % m);
        if (32'(req.smp_cnt) < eff) pool_cnt[s] = 32'(req.smp_cnt);

        step_hi = (cur_idle == 0) ? 64'd1 :
                  ((cur_idle > 2000) ? 64'd2000 : {1'b0, cur_idle});
        r = $urandom_range(0, 99);
        if (r < 5) t = {1'b0, pool_ts[s]} + {1'b0, cur_idle} + 64'($urandom_range(1, 1000));
        else if (r < 9) t = {1'b0, pool_ts[s]} - 64'($urandom_range(1, 500));
        else t = {1'b0, pool_ts[s]} + 64'($urandom_range(1, 32'(step_hi)));
        req.has_timestamp = ($urandom_range(0, 99) < 88);
        req.rx_time_ns    = t[TIME_W-1:0];
        if (req.has_timestamp) pool_ts[s] = t[TIME_W-1:0];
        return req;
    endfunction

    function automatic t_in_item random_request();
        t_in_item req;
        int r, s;
        r = $urandom_range(0, 99);
        s = $urandom_range(0, MAX_ENTRIES - 1);
        if (r < 72) return next_frame(s);
        req.kind          = KIND_FRAME;
        req.app_id        = 16'($urandom);
        req.sv_key        = rand64();
        req.smp_cnt       = 16'($urandom);
        req.has_timestamp = 1'($urandom);
        req.rx_time_ns    = TIME_W'(rand64());
        // unknown-stream frames only once the table is full, so the known
        // streams keep their entries
        if (r < 82 || r >= 92 || (r >= 87 && sb.used < MAX_ENTRIES)) begin
            req.app_id = pool_app[s];
            req.sv_key = pool_key[s];
        end
        if (r < 87) req.kind = KIND_LOOKUP;
        return req;
    endfunction

    task automatic send_request(input t_in_item req);
        int gap_len;
        gap_len = idle_len();
        if (gap_len > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap_len) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= req;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_request(req);
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_reg(idx, data);
        if (idx == CFG_MODULUS) cur_mod = data[MOD_W-1:0];
        else cur_idle = data[TIME_W-1:0];
        @(posedge i_clk);
    endtask

    // hold the request side until every expected result is back
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) sb.check_report(o_out);
            if (hold_req) begin
                stall_left = HOLD_CYCLES;
                hold_req   = 1'b0;
            end else if (stall_left == 0 && $urandom_range(0, 3) == 0) begin
                stall_left = idle_len();
            end
            if (stall_left > 0) begin
                i_out_stall <= 1'b1;
                stall_left--;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    initial begin : stimulus
        int n_items;
        logic [MOD_W-1:0] mod_set;
        logic [TIME_W-1:0] idle_set, t0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            pool_app[i] = 16'($urandom);
            pool_key[i] = rand64();
            pool_cnt[i] = 0;
            pool_ts[i]  = TIME_W'(rand64() >> 2);
        end
        pool_app[2] = 16'h0000;
        pool_key[2] = 64'h0;
        pool_app[3] = 16'hFFFF;
        pool_key[3] = '1;
        t0 = pool_ts[0];

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed pass at the reset settings (modulus 4000, 1 s idle)
        send_request(lookup_req(0));                          // stream not yet known
        send_request(frame_req(0, 4000, 1, t0));              // count at the modulus
        send_request(frame_req(0, 65535, 0, t0));             // count at top of field
        send_request(frame_req(0, 10, 1, t0));                // first frame seeds
        send_request(frame_req(0, 11, 1, t0 + 63'd100));
        send_request(frame_req(0, 15, 1, t0 + 63'd200));      // three missed
        send_request(frame_req(0, 15, 1, t0 + 63'd300));      // duplicate
        send_request(frame_req(0, 12, 0, t0));                // late
        send_request(frame_req(0, 2015, 1, t0 + 63'd400));    // advance of exactly half
        send_request(frame_req(0, 0, 1, t0 + 63'd500));       // restart
        send_request(frame_req(0, 1, 0, t0));
        send_request(frame_req(0, 500, 1, t0 + 63'd2000000000)); // idle reseed
        send_request(frame_req(0, 501, 1, t0 + 63'd700));     // earlier time, no reseed
        send_request(frame_req(1, 3998, 1, pool_ts[1]));
        send_request(frame_req(1, 3999, 1, pool_ts[1] + 63'd10));
        send_request(frame_req(1, 0, 1, pool_ts[1] + 63'd20)); // wrap through zero
        send_request(frame_req(2, 0, 0, '0));                 // seed without a time
        send_request(frame_req(2, 1, 1, '1));                 // first time, largest value
        send_request(frame_req(3, 3999, 1, '0));
        send_request(frame_req(3, 3999, 1, 63'd1000000001));  // just over the idle time
        send_request(frame_req(3, 1, 1, 63'd2000000001));     // exactly the idle time
        send_request(lookup_req(0));
        send_request(lookup_req(3));

        for (int p = 0; p < NUM_PHASES; p++) begin
            drain();
            case (p)
                0: begin mod_set = 17'd4000;   idle_set = 63'd1000000000; n_items = 280; end
                1: begin mod_set = 17'd0;      idle_set = 63'd0;          n_items = 150; end
                2: begin mod_set = 17'd65536;  idle_set = '1;             n_items = 300; end
                3: begin mod_set = 17'd1;      idle_set = 63'd5000;       n_items = 150; end
                4: begin mod_set = 17'd131071; idle_set = 63'd100;        n_items = 300; end
                5: begin mod_set = 17'd2;      idle_set = 63'd1;          n_items = 150; end
                default: begin mod_set = 17'd7; idle_set = 63'd1000;     n_items = 320; end
            endcase
            write_reg(CFG_MODULUS, CFG_W'(mod_set));
            write_reg(CFG_IDLE_NS, idle_set);
            for (int k = 0; k < n_items; k++) begin
                burst = (k >= n_items / 2 && k < n_items / 2 + 40);
                // long receiver hold while requests keep coming
                if (p == 0 && k == 60) hold_req = 1'b1;
                send_request(random_request());
            end
            burst = 1'b0;
        end

        drain();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        $display("Checked %0d results from %0d frames and %0d lookups over %0d settings.",
                 sb.checked, sb.n_frames, sb.n_lookups, NUM_PHASES + 1);
        $display("Outcomes: ok %0d, table full %0d, not found %0d, count out of range %0d.",
                 sb.st_count[ST_OK], sb.st_count[ST_TABLE_FULL],
                 sb.st_count[ST_NOT_FOUND], sb.st_count[ST_OUT_OF_RANGE]);
        if (sb.errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
